// ===== rtl/bpb_pkg.sv =====
package bpb_pkg;

    // fixed field widths
    localparam int ADDR_W = 32;
    localparam int INST_W = 32;

    // default table depth
    localparam int TABLE_ENTRIES_DEF = 16;

    // opcodes of the control-flow instructions
    localparam logic [6:0] OPC_COND_BR  = 7'h63;
    localparam logic [6:0] OPC_JAL      = 7'h6f;
    localparam logic [6:0] OPC_IND_JUMP = 7'h67;

    // branch kind codes
    localparam logic [1:0] KIND_COND = 2'd0;
    localparam logic [1:0] KIND_JAL  = 2'd1;
    localparam logic [1:0] KIND_JALR = 2'd2;

    // predictor mode codes
    localparam logic [2:0] MODE_NONE    = 3'd0;
    localparam logic [2:0] MODE_ALWAYS  = 3'd1;
    localparam logic [2:0] MODE_BTFN    = 3'd2;
    localparam logic [2:0] MODE_BIMODAL = 3'd3;
    localparam logic [2:0] MODE_BTB     = 3'd4;

    // 2-bit counter limits and reset value
    localparam logic [1:0] CTR_MIN   = 2'd0;
    localparam logic [1:0] CTR_MAX   = 2'd3;
    localparam logic [1:0] CTR_RESET = 2'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] seq_next_pc;
        logic [ADDR_W-1:0] actual_next_pc;
        logic [INST_W-1:0] instruction;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        branch_kind;
        logic              predicted_taken;
        logic [ADDR_W-1:0] predicted_next_pc;
        logic              buffer_hit;
        logic              act_taken;
        logic              direction_correct;
        logic              next_pc_correct;
    } t_out_item;

    // one table row: direction counter plus target buffer entry
    typedef struct packed {
        logic [1:0]        ctr;
        logic              vld;
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] tgt;
        logic [1:0]        kind;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        ctr:  CTR_RESET,
        vld:  1'b0,
        tag:  '0,
        tgt:  '0,
        kind: KIND_COND
    };

    // result of one lookup, handed from the predictor to the control
    typedef struct packed {
        logic   is_branch;
        logic   wr_en;
        t_entry wr_entry;
    } t_upd;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage

// ===== rtl/bpb_ram.sv =====
module bpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bpb_predict.sv =====
module bpb_predict (
    input  bpb_pkg::t_in_item  i_item,
    input  logic [2:0]         i_mode,
    input  bpb_pkg::t_entry    i_entry,
    output bpb_pkg::t_out_item o_result,
    output bpb_pkg::t_upd      o_upd
);

    logic [6:0]                  opcode;
    logic                        is_branch;
    logic [1:0]                  kind;
    logic [bpb_pkg::ADDR_W-1:0]  imm_b;
    logic [bpb_pkg::ADDR_W-1:0]  imm_j;
    logic [bpb_pkg::ADDR_W-1:0]  target;
    logic [2:0]                  mode;
    logic                        actual;
    logic                        taken;
    logic                        hit;
    logic [bpb_pkg::ADDR_W-1:0]  next_pc;
    logic                        ctr_upd;
    logic                        buf_upd;
    logic [1:0]                  ctr_new;
    bpb_pkg::t_entry             entry_new;

    // opcode decode
    assign opcode = i_item.instruction[6:0];

    always_comb begin
        is_branch = 1'b1;
        kind      = bpb_pkg::KIND_COND;
        unique case (opcode)
            bpb_pkg::OPC_COND_BR:  kind = bpb_pkg::KIND_COND;
            bpb_pkg::OPC_JAL:      kind = bpb_pkg::KIND_JAL;
            bpb_pkg::OPC_IND_JUMP: kind = bpb_pkg::KIND_JALR;
            default:               is_branch = 1'b0;
        endcase
    end

    // b and j immediates, sign extended
    assign imm_b = {{19{i_item.instruction[31]}}, i_item.instruction[31],
                    i_item.instruction[7], i_item.instruction[30:25],
                    i_item.instruction[11:8], 1'b0};
    assign imm_j = {{11{i_item.instruction[31]}}, i_item.instruction[31],
                    i_item.instruction[19:12], i_item.instruction[20],
                    i_item.instruction[30:21], 1'b0};

    assign target = i_item.pc + ((kind == bpb_pkg::KIND_JAL) ? imm_j : imm_b);

    // undefined modes behave as no prediction
    assign mode   = (i_mode > bpb_pkg::MODE_BTB) ? bpb_pkg::MODE_NONE : i_mode;
    assign actual = i_item.actual_next_pc != i_item.seq_next_pc;

    // prediction from the old table row
    always_comb begin
        taken   = 1'b0;
        hit     = 1'b0;
        next_pc = i_item.seq_next_pc;
        unique case (mode)
            bpb_pkg::MODE_BTB: begin
                if (i_entry.vld && (i_entry.tag == i_item.pc)) begin
                    hit   = 1'b1;
                    taken = (i_entry.kind == bpb_pkg::KIND_COND) ? i_entry.ctr[1] : 1'b1;
                    if (taken) begin
                        next_pc = i_entry.tgt;
                    end
                end
            end
            bpb_pkg::MODE_ALWAYS: begin
                taken = 1'b1;
            end
            bpb_pkg::MODE_BTFN: begin
                taken = (kind == bpb_pkg::KIND_COND) ? i_item.instruction[31] : 1'b1;
            end
            bpb_pkg::MODE_BIMODAL: begin
                taken = (kind == bpb_pkg::KIND_COND) ? i_entry.ctr[1] : 1'b1;
            end
            default: begin
                taken = 1'b0;
            end
        endcase
        if ((mode != bpb_pkg::MODE_BTB) && taken && (kind != bpb_pkg::KIND_JALR)) begin
            next_pc = target;
        end
    end

    assign o_result.branch_kind       = kind;
    assign o_result.predicted_taken   = taken;
    assign o_result.predicted_next_pc = next_pc;
    assign o_result.buffer_hit        = hit;
    assign o_result.act_taken         = actual;
    assign o_result.direction_correct = taken == actual;
    assign o_result.next_pc_correct   = next_pc == i_item.actual_next_pc;

    // training: saturating counter and buffer refill
    assign ctr_upd = ((mode == bpb_pkg::MODE_BIMODAL) || (mode == bpb_pkg::MODE_BTB))
                     && (kind == bpb_pkg::KIND_COND);
    assign buf_upd = (mode == bpb_pkg::MODE_BTB) && (actual || (kind != bpb_pkg::KIND_COND));

    always_comb begin
        ctr_new = i_entry.ctr;
        if (ctr_upd) begin
            if (actual) begin
                if (i_entry.ctr != bpb_pkg::CTR_MAX) begin
                    ctr_new = i_entry.ctr + 2'd1;
                end
            end else if (i_entry.ctr != bpb_pkg::CTR_MIN) begin
                ctr_new = i_entry.ctr - 2'd1;
            end
        end
    end

    always_comb begin
        entry_new     = i_entry;
        entry_new.ctr = ctr_new;
        if (buf_upd) begin
            entry_new.vld  = 1'b1;
            entry_new.tag  = i_item.pc;
            entry_new.tgt  = i_item.actual_next_pc;
            entry_new.kind = kind;
        end
    end

    assign o_upd.is_branch = is_branch;
    assign o_upd.wr_en     = is_branch && (ctr_upd || buf_upd);
    assign o_upd.wr_entry  = entry_new;

endmodule

// ===== rtl/branch_predictor_bimodal_btb_core.sv =====
// path: an accepted record is registered into the lookup stage with its table read,
// then its result and result strobe are registered in the result register
// throughput: one record per cycle while busy is low, set by the single
// read-modify-write table memory (one read and one write a cycle, a same-row write
// is forwarded to the next read). reset: the mode register clears to 0; then a clearing
// pass rewrites every row while busy is high. the receiver cannot stall results
module branch_predictor_bimodal_btb_core #(
    parameter int TABLE_ENTRIES = bpb_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bpb_pkg::t_in_item  i_item,
    output logic               o_result_valid,
    output bpb_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_data
);

    localparam int                IDXW     = $clog2(TABLE_ENTRIES);
    localparam int                EW       = $bits(bpb_pkg::t_entry);
    localparam logic [IDXW-1:0]   LAST_IDX = IDXW'(TABLE_ENTRIES - 1);

    bpb_pkg::t_state    r_state, n_state;
    logic [IDXW-1:0]    r_clr_idx, n_clr_idx;
    logic [2:0]         r_mode;
    logic               r_look;
    bpb_pkg::t_in_item  r_item;
    logic [IDXW-1:0]    r_idx;
    logic               r_fwd;
    bpb_pkg::t_entry    r_fwd_data;
    logic               r_res_vld;
    bpb_pkg::t_out_item r_res;

    logic               accept;
    logic               clearing;
    logic [IDXW-1:0]    rd_idx;
    logic               ram_we;
    logic [IDXW-1:0]    ram_waddr;
    bpb_pkg::t_entry    ram_wdata;
    logic [EW-1:0]      ram_rdata;
    bpb_pkg::t_entry    entry_old;
    bpb_pkg::t_out_item result;
    bpb_pkg::t_upd      upd;

    assign clearing = r_state == bpb_pkg::ST_CLEAR;
    assign busy     = clearing;
    assign accept   = start && !busy;
    assign rd_idx   = i_item.pc[IDXW+1:2];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bpb_pkg::ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    // clearing pass sequencing
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        unique case (r_state)
            bpb_pkg::ST_CLEAR: begin
                n_clr_idx = r_clr_idx + IDXW'(1);
                if (r_clr_idx == LAST_IDX) begin
                    n_state   = bpb_pkg::ST_RUN;
                    n_clr_idx = '0;
                end
            end
            bpb_pkg::ST_RUN: begin
                n_state = bpb_pkg::ST_RUN;
            end
            default: begin
                n_state = bpb_pkg::ST_CLEAR;
            end
        endcase
    end

    // mode register transfer, only with no record in flight or being taken in
    assign o_cfg_ready = !r_look && !accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bpb_pkg::MODE_NONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // write port: clearing pass or training write-back
    assign ram_we    = clearing || (r_look && upd.wr_en);
    assign ram_waddr = clearing ? r_clr_idx : r_idx;
    assign ram_wdata = clearing ? bpb_pkg::ENTRY_RESET : upd.wr_entry;

    bpb_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_idx),
        .o_rdata (ram_rdata)
    );

    // lookup stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look <= 1'b0;
            r_fwd  <= 1'b0;
        end else begin
            r_look <= accept;
            r_fwd  <= accept && ram_we && (ram_waddr == rd_idx);
        end
    end

    // lookup stage payload and forwarded row
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
            r_idx  <= rd_idx;
        end
        r_fwd_data <= ram_wdata;
    end

    assign entry_old = r_fwd ? r_fwd_data : bpb_pkg::t_entry'(ram_rdata);

    bpb_predict u_predict (
        .i_item   (r_item),
        .i_mode   (r_mode),
        .i_entry  (entry_old),
        .o_result (result),
        .o_upd    (upd)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_look && upd.is_branch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_look) begin
            r_res <= result;
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    // a result only follows a lookup of a control-flow record
    a_res_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_look))
        else $error("result strobe without a preceding lookup");

    // no record is looked up while the table is being cleared
    a_no_look_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !r_look)
        else $error("lookup during clearing pass");

    // forwarding only applies to a record in lookup
    a_fwd_needs_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_look)
        else $error("forwarded row without a lookup");

    // every reported kind is a known one
    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.branch_kind == bpb_pkg::KIND_COND ||
                            o_result.branch_kind == bpb_pkg::KIND_JAL ||
                            o_result.branch_kind == bpb_pkg::KIND_JALR))
        else $error("unknown branch kind reported");

endmodule
